// File: src/mesh_shortest_path_search_top_defines.svh
// Assertion macros used by the checker file of the shortest path search block.
// No dependencies.
`ifndef MESH_SHORTEST_PATH_SEARCH_TOP_DEFINES_SVH
`define MESH_SHORTEST_PATH_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define MSPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/msps_pkg.sv
// Package of the mesh shortest path search block: word types, codes, defaults.
// No dependencies.
package msps_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_DEGREE_DEF   = 8;
    localparam int COST_BITS_DEF    = 24;

    // Operation codes of an input word
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    // unused code, dropped without a result
    localparam logic [1:0] OP_NONE = 2'd3;

    // Result kinds
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Visit marks
    localparam logic [1:0] VS_UNTOUCHED = 2'd0;
    localparam logic [1:0] VS_QUEUED    = 2'd1;
    localparam logic [1:0] VS_DONE      = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_VERTEX_COUNT     = 3'd0;
    localparam logic [2:0] REG_START_VERTEX     = 3'd1;
    localparam logic [2:0] REG_END_VERTEX       = 3'd2;
    localparam logic [2:0] REG_MAX_COST         = 3'd3;
    localparam logic [2:0] REG_PRESERVE_HISTORY = 3'd4;
    localparam logic [2:0] REG_CLEAR_COSTS      = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  vertex;
        logic [2:0]  slot;
        logic [9:0]  neighbor;
        logic [23:0] edge_cost;
        logic [3:0]  degree;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic        success;
        logic [9:0]  vertex_out;
        logic [23:0] path_cost;
        logic        reached;
        logic [9:0]  predecessor;
        logic [1:0]  visit_state;
    } t_out_word;

endpackage

// File: src/msps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mesh_shortest_path_search_top.sv
// Load: words are taken back to back while idle. Read: the vertex record is read in ST_IDLE and
// registered into the output register in ST_PUT. Run: a mark sweep over the n vertices plus setup
// and result, then per popped vertex a queue minimum scan through the single queue RAM read port and
// the pop, plus read, check and update steps per neighbor slot (no update when out of range).
// Reset (synchronous, active low) starts a clearing pass over all MAX_VERTICES entries of the vertex
// and degree memories; input words stall during it, register writes are taken.
module mesh_shortest_path_search_top #(
    parameter int MAX_VERTICES = msps_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = msps_pkg::MAX_DEGREE_DEF,
    parameter int COST_BITS    = msps_pkg::COST_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  msps_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output msps_pkg::t_out_word o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = VW + 1;
    localparam int DW  = $clog2(MAX_DEGREE);
    localparam int DGW = $clog2(MAX_DEGREE + 1);
    localparam int SQW = VW + 1;
    localparam int ADJ_DEPTH = MAX_VERTICES * (1 << DW);
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic [VW-1:0]        pred;
        logic                 reached;
        logic [1:0]           mark;
    } t_vrec;

    typedef struct packed {
        logic [VW-1:0]        vtx;
        logic [COST_BITS-1:0] key;
        logic [SQW-1:0]       seq;
    } t_qent;

    typedef struct packed {
        logic [9:0]           nb;
        logic [COST_BITS-1:0] ec;
    } t_adj;

    typedef enum logic [15:0] {
        ST_CLR     = 16'b0000_0000_0000_0001,
        ST_IDLE    = 16'b0000_0000_0000_0010,
        ST_RUN     = 16'b0000_0000_0000_0100,
        ST_INIT_RD = 16'b0000_0000_0000_1000,
        ST_INIT_WR = 16'b0000_0000_0001_0000,
        ST_SEED    = 16'b0000_0000_0010_0000,
        ST_LOOP    = 16'b0000_0000_0100_0000,
        ST_SCAN    = 16'b0000_0000_1000_0000,
        ST_POP_RD  = 16'b0000_0001_0000_0000,
        ST_POP_WR  = 16'b0000_0010_0000_0000,
        ST_CUR_WR  = 16'b0000_0100_0000_0000,
        ST_NB_RD   = 16'b0000_1000_0000_0000,
        ST_NB_CHK  = 16'b0001_0000_0000_0000,
        ST_NB_UPD  = 16'b0010_0000_0000_0000,
        ST_FIN_RD  = 16'b0100_0000_0000_0000,
        ST_PUT     = 16'b1000_0000_0000_0000
    } t_state;

    // configuration registers
    logic [10:0] r_vertex_count;
    logic [9:0]  r_start_vertex;
    logic [9:0]  r_end_vertex;
    logic [23:0] r_max_cost;
    logic        r_preserve_history;
    logic        r_clear_costs;

    t_state               r_state, n_state;
    logic [NW-1:0]        r_idx, n_idx;
    logic [NW-1:0]        r_k, n_k;
    logic [NW-1:0]        r_qlen, n_qlen;
    logic [SQW-1:0]       r_seq, n_seq;
    logic [NW-1:0]        r_qi, n_qi;
    logic [VW-1:0]        r_qd, n_qd;
    logic                 r_dv, n_dv;
    logic                 r_best_any, n_best_any;
    t_qent                r_best, n_best;
    logic [VW-1:0]        r_best_idx, n_best_idx;
    logic [VW-1:0]        r_cur, n_cur;
    logic [COST_BITS-1:0] r_cc, n_cc;
    logic [DGW-1:0]       r_deg, n_deg;
    logic [DGW-1:0]       r_j, n_j;
    logic [VW-1:0]        r_nb, n_nb;
    logic [COST_BITS-1:0] r_f, n_f;
    logic                 r_ok, n_ok;
    logic                 r_kind, n_kind;
    logic [9:0]           r_vout, n_vout;
    logic                 r_out_valid, n_out_valid;
    msps_pkg::t_out_word  r_out, n_out;

    // memory ports
    logic                 v_we, v_re;
    logic [VW-1:0]        v_waddr, v_raddr;
    t_vrec                v_wdata, v_rdata;
    logic                 d_we, d_re;
    logic [VW-1:0]        d_waddr, d_raddr;
    logic [DGW-1:0]       d_wdata, d_rdata;
    logic                 a_we, a_re;
    logic [VW+DW-1:0]     a_waddr, a_raddr;
    t_adj                 a_wdata, a_rdata;
    logic                 q_we, q_re;
    logic [VW-1:0]        q_waddr, q_raddr;
    t_qent                q_wdata, q_rdata;

    logic                 w_accept;
    logic [NW-1:0]        w_nv;
    logic                 w_cfg_wr;
    logic [COST_BITS:0]   w_sum;
    logic [COST_BITS-1:0] w_fsat;
    logic                 w_untouched, w_lower, w_wr, w_skip, w_better;

    msps_ram #(.WIDTH($bits(t_vrec)), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_re(v_re), .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    msps_ram #(.WIDTH(DGW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_re(d_re), .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    msps_ram #(.WIDTH($bits(t_adj)), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(a_re), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    msps_ram #(.WIDTH($bits(t_qent)), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;

    assign w_nv = (32'(r_vertex_count) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                             : NW'(r_vertex_count);

    // adder: path cost plus edge cost, saturated
    assign w_sum  = {1'b0, r_cc} + {1'b0, a_rdata.ec};
    assign w_fsat = w_sum[COST_BITS] ? COST_MAX : w_sum[COST_BITS-1:0];

    // relaxation decision on the neighbor record just read
    assign w_untouched = (v_rdata.mark == msps_pkg::VS_UNTOUCHED);
    assign w_lower     = v_rdata.reached && (r_f < v_rdata.cost);
    assign w_wr        = (w_untouched || w_lower)
                         && (!r_preserve_history || !v_rdata.reached || w_lower);
    assign w_skip      = (v_rdata.mark == msps_pkg::VS_DONE)
                         || ((r_max_cost != '0) && (32'(r_f) > 32'(r_max_cost)));

    // queue order: smaller key first, then earlier insertion
    assign w_better = !r_best_any || (q_rdata.key < r_best.key)
                      || ((q_rdata.key == r_best.key) && (q_rdata.seq < r_best.seq));

    always_comb begin
        case (paddr[4:2])
            msps_pkg::REG_VERTEX_COUNT:     prdata = 32'(r_vertex_count);
            msps_pkg::REG_START_VERTEX:     prdata = 32'(r_start_vertex);
            msps_pkg::REG_END_VERTEX:       prdata = 32'(r_end_vertex);
            msps_pkg::REG_MAX_COST:         prdata = 32'(r_max_cost);
            msps_pkg::REG_PRESERVE_HISTORY: prdata = 32'(r_preserve_history);
            msps_pkg::REG_CLEAR_COSTS:      prdata = 32'(r_clear_costs);
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count     <= 11'd1024;
            r_start_vertex     <= '0;
            r_end_vertex       <= '0;
            r_max_cost         <= '0;
            r_preserve_history <= 1'b0;
            r_clear_costs      <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                msps_pkg::REG_VERTEX_COUNT:     r_vertex_count     <= pwdata[10:0];
                msps_pkg::REG_START_VERTEX:     r_start_vertex     <= pwdata[9:0];
                msps_pkg::REG_END_VERTEX:       r_end_vertex       <= pwdata[9:0];
                msps_pkg::REG_MAX_COST:         r_max_cost         <= pwdata[23:0];
                msps_pkg::REG_PRESERVE_HISTORY: r_preserve_history <= pwdata[0];
                msps_pkg::REG_CLEAR_COSTS:      r_clear_costs      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_k         = r_k;
        n_qlen      = r_qlen;
        n_seq       = r_seq;
        n_qi        = r_qi;
        n_qd        = r_qd;
        n_dv        = 1'b0;
        n_best_any  = r_best_any;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_cur       = r_cur;
        n_cc        = r_cc;
        n_deg       = r_deg;
        n_j         = r_j;
        n_nb        = r_nb;
        n_f         = r_f;
        n_ok        = r_ok;
        n_kind      = r_kind;
        n_vout      = r_vout;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        v_we    = 1'b0;
        v_waddr = r_idx[VW-1:0];
        v_wdata = v_rdata;
        v_re    = 1'b0;
        v_raddr = r_idx[VW-1:0];
        d_we    = 1'b0;
        d_waddr = r_idx[VW-1:0];
        d_wdata = '0;
        d_re    = 1'b0;
        d_raddr = r_best.vtx;
        a_we    = 1'b0;
        a_waddr = {VW'(i_in.vertex), DW'(i_in.slot)};
        a_wdata = '{nb: i_in.neighbor, ec: COST_BITS'(i_in.edge_cost)};
        a_re    = 1'b0;
        a_raddr = {r_cur, r_j[DW-1:0]};
        q_we    = 1'b0;
        q_waddr = r_qlen[VW-1:0];
        q_wdata = r_best;
        q_re    = 1'b0;
        q_raddr = r_qi[VW-1:0];

        case (r_state)
            ST_CLR: begin
                v_we    = 1'b1;
                v_wdata = '{cost: '0, pred: '0, reached: 1'b0, mark: msps_pkg::VS_UNTOUCHED};
                d_we    = 1'b1;
                if (r_idx == NW'(MAX_VERTICES - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.op)
                        msps_pkg::OP_LOAD: begin
                            if (32'(i_in.vertex) < 32'(MAX_VERTICES)) begin
                                a_we    = (32'(i_in.slot) < 32'(MAX_DEGREE));
                                d_we    = 1'b1;
                                d_waddr = VW'(i_in.vertex);
                                d_wdata = (32'(i_in.degree) > 32'(MAX_DEGREE))
                                          ? DGW'(MAX_DEGREE) : DGW'(i_in.degree);
                            end
                        end
                        msps_pkg::OP_RUN: begin
                            n_state = ST_RUN;
                        end
                        msps_pkg::OP_READ: begin
                            v_re    = 1'b1;
                            v_raddr = VW'(i_in.vertex);
                            n_kind  = msps_pkg::KIND_READ;
                            n_ok    = 1'b1;
                            n_vout  = i_in.vertex;
                            n_state = ST_PUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                n_idx = '0;
                if ((32'(r_start_vertex) < 32'(w_nv)) && (32'(r_end_vertex) < 32'(w_nv))) begin
                    n_state = ST_INIT_RD;
                end else begin
                    n_ok    = 1'b0;
                    n_state = ST_FIN_RD;
                end
            end
            ST_INIT_RD: begin
                v_re    = 1'b1;
                n_state = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                v_we         = 1'b1;
                v_wdata.mark = msps_pkg::VS_UNTOUCHED;
                if (r_clear_costs) begin
                    v_wdata.reached = 1'b0;
                end
                if (r_idx + NW'(1) == w_nv) begin
                    n_state = ST_SEED;
                end else begin
                    n_idx   = r_idx + NW'(1);
                    n_state = ST_INIT_RD;
                end
            end
            ST_SEED: begin
                v_we    = 1'b1;
                v_waddr = VW'(r_start_vertex);
                v_wdata = '{cost: '0, pred: VW'(r_end_vertex), reached: 1'b1,
                            mark: msps_pkg::VS_QUEUED};
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '{vtx: VW'(r_start_vertex), key: '0, seq: '0};
                n_qlen  = NW'(1);
                n_seq   = SQW'(1);
                n_k     = '0;
                n_state = ST_LOOP;
            end
            ST_LOOP: begin
                if (32'(r_k) + 32'd1 >= 32'(w_nv)) begin
                    n_ok    = 1'b1;
                    n_state = ST_FIN_RD;
                end else if (r_qlen == '0) begin
                    n_ok    = 1'b0;
                    n_state = ST_FIN_RD;
                end else begin
                    n_qi       = '0;
                    n_best_any = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one queue read per cycle, compare the word from the previous read
                if (r_qi != r_qlen) begin
                    q_re = 1'b1;
                    n_qi = r_qi + NW'(1);
                    n_qd = r_qi[VW-1:0];
                    n_dv = 1'b1;
                end
                if (r_dv && w_better) begin
                    n_best_any = 1'b1;
                    n_best     = q_rdata;
                    n_best_idx = r_qd;
                end
                if ((r_qi == r_qlen) && !r_dv) begin
                    n_state = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                q_re    = 1'b1;
                q_raddr = VW'(r_qlen - NW'(1));
                n_state = ST_POP_WR;
            end
            ST_POP_WR: begin
                // fill the hole with the last entry, fetch the popped vertex
                q_we    = 1'b1;
                q_waddr = r_best_idx;
                q_wdata = q_rdata;
                n_qlen  = r_qlen - NW'(1);
                v_re    = 1'b1;
                v_raddr = r_best.vtx;
                d_re    = 1'b1;
                n_cur   = r_best.vtx;
                n_state = ST_CUR_WR;
            end
            ST_CUR_WR: begin
                v_we         = 1'b1;
                v_waddr      = r_cur;
                v_wdata.mark = msps_pkg::VS_DONE;
                n_cc         = v_rdata.cost;
                n_deg        = d_rdata;
                n_j          = '0;
                n_state      = ST_NB_RD;
            end
            ST_NB_RD: begin
                if (r_j == r_deg) begin
                    if ((32'(r_cur) == 32'(r_end_vertex)) && (r_k != '0)) begin
                        n_ok    = 1'b1;
                        n_state = ST_FIN_RD;
                    end else begin
                        n_k     = r_k + NW'(1);
                        n_state = ST_LOOP;
                    end
                end else begin
                    a_re    = 1'b1;
                    n_state = ST_NB_CHK;
                end
            end
            ST_NB_CHK: begin
                if (32'(a_rdata.nb) >= 32'(w_nv)) begin
                    n_j     = r_j + DGW'(1);
                    n_state = ST_NB_RD;
                end else begin
                    v_re    = 1'b1;
                    v_raddr = VW'(a_rdata.nb);
                    n_nb    = VW'(a_rdata.nb);
                    n_f     = w_fsat;
                    n_state = ST_NB_UPD;
                end
            end
            ST_NB_UPD: begin
                v_waddr = r_nb;
                if (!w_skip) begin
                    v_we = w_wr || w_untouched;
                    if (w_wr) begin
                        v_wdata.cost    = r_f;
                        v_wdata.pred    = r_cur;
                        v_wdata.reached = 1'b1;
                    end
                    if (w_untouched) begin
                        v_wdata.mark = msps_pkg::VS_QUEUED;
                        q_we    = 1'b1;
                        q_wdata = '{vtx: r_nb, key: (w_wr ? r_f : v_rdata.cost), seq: r_seq};
                        n_qlen  = r_qlen + NW'(1);
                        n_seq   = r_seq + SQW'(1);
                    end
                end
                n_j     = r_j + DGW'(1);
                n_state = ST_NB_RD;
            end
            ST_FIN_RD: begin
                v_re    = 1'b1;
                v_raddr = VW'(r_end_vertex);
                n_kind  = msps_pkg::KIND_RUN;
                n_vout  = r_end_vertex;
                n_qlen  = '0;
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.kind        = r_kind;
                    n_out.success     = r_ok;
                    n_out.vertex_out  = r_vout;
                    if (32'(r_vout) < 32'(MAX_VERTICES)) begin
                        n_out.reached     = v_rdata.reached;
                        n_out.visit_state = v_rdata.mark;
                        if (v_rdata.reached) begin
                            n_out.path_cost   = 24'(v_rdata.cost);
                            n_out.predecessor = 10'(v_rdata.pred);
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_idx       <= '0;
            r_k         <= '0;
            r_qlen      <= '0;
            r_seq       <= '0;
            r_qi        <= '0;
            r_dv        <= 1'b0;
            r_best_any  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_qlen      <= n_qlen;
            r_seq       <= n_seq;
            r_qi        <= n_qi;
            r_dv        <= n_dv;
            r_best_any  <= n_best_any;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qd       <= n_qd;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_cur      <= n_cur;
        r_cc       <= n_cc;
        r_deg      <= n_deg;
        r_j        <= n_j;
        r_nb       <= n_nb;
        r_f        <= n_f;
        r_ok       <= n_ok;
        r_kind     <= n_kind;
        r_vout     <= n_vout;
        r_out      <= n_out;
    end

endmodule

// File: src/msps_checker.sv
// Port-level checks of the mesh shortest path search block, bound to the top level.
// Depends on msps_pkg and mesh_shortest_path_search_top_defines.svh.
`include "mesh_shortest_path_search_top_defines.svh"

module msps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input msps_pkg::t_in_word  i_in,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input msps_pkg::t_out_word o_out
);

    logic w_cmd_taken;
    logic w_unreached_out;
    logic w_no_data;
    logic w_read_out;

    assign w_cmd_taken     = i_in_valid && !o_in_stall
                             && (i_in.op == msps_pkg::OP_RUN || i_in.op == msps_pkg::OP_READ);
    assign w_unreached_out = o_out_valid && !o_out.reached;
    assign w_no_data       = (o_out.path_cost == '0) && (o_out.predecessor == '0);
    assign w_read_out      = o_out_valid && (o_out.kind == msps_pkg::KIND_READ);

    // a result word stays offered until taken
    `MSPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a taken run or read word makes the block busy, so further input words stall
    `MSPS_ASSERT_NXT(a_busy_after_cmd, i_clk, i_rst_n, w_cmd_taken, o_in_stall)

    // unreached vertices report no cost and no predecessor
    `MSPS_ASSERT_IMP(a_unreached_zero, i_clk, i_rst_n, w_unreached_out, w_no_data)

    // read results always report success
    `MSPS_ASSERT_IMP(a_read_success, i_clk, i_rst_n, w_read_out, o_out.success)

endmodule

bind mesh_shortest_path_search_top msps_checker u_msps_checker (.*);
